/* src/sha1_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants for the sha-1 digest engine
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // one classified word handed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } sha1_item_t;

endpackage
`default_nettype wire

/* src/sha1_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_front
// accepts message words, saturates the byte count of the last word (others count four) and queues them
// ----------------------------------------------------------------------------
module sha1_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [31:0]          in_word,
    input  wire  [2:0]           in_nbytes,
    input  wire                  in_last,
    output logic                 q_valid,
    input  wire                  q_ready,
    output sha1_pkg::sha1_item_t q_item
);
    import sha1_pkg::*;

    sha1_item_t     mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    sha1_item_t     item;
    logic           push, pop;

    assign in_ready = (cnt_reg != QDEPTH[QAW:0]);
    assign q_valid  = (cnt_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = mem[rp_reg];

    always_comb begin
        item.word   = in_word;
        item.last   = in_last;
        if (!in_last) begin
            item.nbytes = 3'd4;
        end else if (in_nbytes > 3'd4) begin
            item.nbytes = 3'd4;
        end else begin
            item.nbytes = in_nbytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
        end
    end

endmodule
`default_nettype wire

/* src/sha1_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_back
// packs words into blocks, pads, runs 80 rounds and emits the digest
// ----------------------------------------------------------------------------
module sha1_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_valid,
    output logic                 q_ready,
    input  sha1_pkg::sha1_item_t q_item,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [31:0]          m_word,
    output logic [2:0]           m_index,
    output logic                 m_final
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  state_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] len_reg;
    logic [3:0]  pos_reg;
    logic [6:0]  t_reg;
    logic        fin_reg;     // digest follows this compression
    logic        padx_reg;    // 0x80 word still owed (full last word)
    logic        pad_reg;     // padding of the current message in progress
    logic        lenok_reg;   // length words go into the current block
    logic [2:0]  oi_reg;

    logic [31:0] wt, f, k, tmp, keep, padw, push_w;
    logic        do_push, take;
    logic [1:0]  rg;

    assign q_ready = (state_reg == S_IDLE);
    assign take    = q_valid && q_ready;
    assign rg      = (t_reg < 7'd20) ? 2'd0 : (t_reg < 7'd40) ? 2'd1 :
                     (t_reg < 7'd60) ? 2'd2 : 2'd3;

    always_comb begin
        if (t_reg < 7'd16) begin
            wt = w_reg[0];
        end else begin
            wt = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
            wt = {wt[30:0], wt[31]};
        end
        case (rg)
            2'd0:    begin f = (b_reg & c_reg) ^ (~b_reg & d_reg); k = K0; end
            2'd1:    begin f = b_reg ^ c_reg ^ d_reg; k = K1; end
            2'd2:    begin
                f = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg); k = K2;
            end
            default: begin f = b_reg ^ c_reg ^ d_reg; k = K3; end
        endcase
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;
    end

    always_comb begin
        case (q_item.nbytes)
            3'd0:    begin keep = 32'h0;        padw = 32'h80000000; end
            3'd1:    begin keep = 32'hff000000; padw = 32'h00800000; end
            3'd2:    begin keep = 32'hffff0000; padw = 32'h00008000; end
            3'd3:    begin keep = 32'hffffff00; padw = 32'h00000080; end
            default: begin keep = 32'hffffffff; padw = 32'h0;        end
        endcase
    end

    // word pushed into the window this cycle
    always_comb begin
        do_push = 1'b0;
        push_w  = '0;
        if (state_reg == S_IDLE && take) begin
            do_push = 1'b1;
            push_w  = (q_item.word & keep) | padw;
        end else if (state_reg == S_PAD) begin
            do_push = 1'b1;
            if (padx_reg)                           push_w = 32'h80000000;
            else if (lenok_reg && pos_reg == 4'd14) push_w = len_reg[63:32];
            else if (lenok_reg && pos_reg == 4'd15) push_w = len_reg[31:0];
            else                                    push_w = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            w_reg[pos_reg] <= push_w;
        end else if (state_reg == S_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_ROUND) begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end else if (do_push && pos_reg == 4'd15) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            h_reg     <= '{H0, H1, H2, H3, H4};
            len_reg   <= '0;
            pos_reg   <= '0;
            t_reg     <= '0;
            fin_reg   <= 1'b0;
            padx_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            lenok_reg <= 1'b0;
            oi_reg    <= '0;
        end else begin
            if (do_push) pos_reg <= pos_reg + 1'b1;
            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        len_reg  <= len_reg + {58'd0, q_item.nbytes, 3'd0};
                        padx_reg <= q_item.last && (q_item.nbytes == 3'd4);
                        pad_reg  <= q_item.last;
                        // room for the 0x80 word and both length words
                        lenok_reg <= (q_item.nbytes == 3'd4) ? (pos_reg <= 4'd12) :
                                                               (pos_reg <= 4'd13);
                        fin_reg  <= 1'b0;
                        t_reg    <= '0;
                        if (pos_reg == 4'd15) begin
                            state_reg <= S_ROUND;
                        end else if (q_item.last) begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    padx_reg <= 1'b0;
                    if (pos_reg == 4'd15) begin
                        fin_reg   <= lenok_reg;
                        t_reg     <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    t_reg <= t_reg + 1'b1;
                    if (t_reg == 7'd79) state_reg <= S_ADD;
                end
                S_ADD: begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    oi_reg   <= '0;
                    if (fin_reg) begin
                        state_reg <= S_OUT;
                    end else if (pad_reg) begin
                        // a fresh padding block always has room for the length
                        lenok_reg <= 1'b1;
                        state_reg <= S_PAD;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        oi_reg <= oi_reg + 1'b1;
                        if (oi_reg == 3'd4) begin
                            h_reg     <= '{H0, H1, H2, H3, H4};
                            len_reg   <= '0;
                            pos_reg   <= '0;
                            fin_reg   <= 1'b0;
                            pad_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = (state_reg == S_OUT);
    assign m_index = oi_reg;
    assign m_final = (oi_reg == 3'd4);
    always_comb begin
        case (oi_reg)
            3'd0:    m_word = h_reg[0];
            3'd1:    m_word = h_reg[1];
            3'd2:    m_word = h_reg[2];
            3'd3:    m_word = h_reg[3];
            default: m_word = h_reg[4];
        endcase
    end

endmodule
`default_nettype wire

/* src/sha1_message_digest.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 digest engine over a stream of big-endian message words
// ----------------------------------------------------------------------------
//  channel  dir  tdata                         tuser         tlast
//  s_axis   in   [31:0] msg_word               [2:0] bytes   last_word
//  m_axis   out  [31:0] digest_word            [2:0] index   final_word
//
//  a word fills one slot of the 16-word window; every 16th word and each padding
//  block start 80 rounds followed by an add step in the shared round unit.
//  a 4-entry queue lets the input keep accepting while rounds run.
//  reset is synchronous and restores the initial hash values.
//  the digest waits in the output stage as long as m_axis_tready is low.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // msg_word
    input  wire  [2:0]  s_axis_tuser,   // valid_bytes
    input  wire         s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // final_word
);
    import sha1_pkg::*;

    sha1_item_t q_item;
    logic       q_valid, q_ready;

    sha1_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s_axis_tdata),
        .in_nbytes (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    sha1_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_word  (m_axis_tdata),
        .m_index (m_axis_tuser),
        .m_final (m_axis_tlast)
    );

endmodule
`default_nettype wire

/* src/sha1_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_checker
// port-level checks on the digest output stream
// ----------------------------------------------------------------------------
module sha1_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
        else $error("tlast does not match index four");

    a_idx_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser <= 3'd4))
        else $error("digest index out of range");

    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest words not back to back in order");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled digest word changed");
endmodule

bind sha1_message_digest sha1_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
